// ===== rtl/pbca_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbca_pkg: shared types and constants
// Pixel payload structs, mode and register codes, and the constants of the
// divide-by-255 reciprocal used by the blend lanes.
// ----------------------------------------------------------------------------
package pbca_pkg;

  // Input transfer: top (working) pixel and bottom pixel, BGR order
  typedef struct packed {
    logic [7:0] top_blue;
    logic [7:0] top_green;
    logic [7:0] top_red;
    logic [7:0] bottom_blue;
    logic [7:0] bottom_green;
    logic [7:0] bottom_red;
  } pix_in_t;

  // Output transfer: result pixel
  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
  } pix_out_t;

  // Operating modes; code 7 is unused and passes the top pixel through
  typedef enum logic [2:0] {
    MODE_MUL    = 3'd0,
    MODE_SUB    = 3'd1,
    MODE_SCREEN = 3'd2,
    MODE_OVL    = 3'd3,
    MODE_ADD    = 3'd4,
    MODE_SCALE  = 3'd5,
    MODE_REPL   = 3'd6
  } mode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_CHSEL  = 2'd1,
    CFG_OFFSET = 2'd2,
    CFG_SCALE  = 2'd3
  } cfg_idx_e;

  // Channel select codes; code 3 selects nothing
  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  localparam int unsigned CfgDataW = 9;

  // Reset values of the configuration registers
  localparam logic [2:0] MODE_RST   = 3'd0;
  localparam logic [1:0] CHSEL_RST  = CH_RED;
  localparam logic [8:0] OFFSET_RST = 9'd0;
  localparam logic [7:0] SCALE_RST  = 8'd1;

  // floor(y / 255) = (y * RecipMul) >> RecipShift, exact for y < 2^17
  localparam logic [17:0] RecipMul   = 18'd131587;
  localparam int unsigned RecipShift = 25;
  localparam logic [16:0] RoundBias  = 17'd127;

  // Stage load enables handed from the top level to the datapath modules
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pbca_en_t;

endpackage
`default_nettype wire

// ===== rtl/pbca_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbca_lane: one color channel blend lane
// Computes multiply, subtract, screen and overlay for one channel pair in two
// register stages: 8x8 product, then rounding divide by 255 via reciprocal.
// ----------------------------------------------------------------------------
module pbca_lane import pbca_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic [2:0] mode_i,
  input  wire pbca_en_t   en_i,
  input  wire logic [7:0] top_i,
  input  wire logic [7:0] bot_i,
  output logic [7:0]      res_o
);

  // Stage 1 decode
  logic       is_sub;
  logic       is_ovl;
  logic       inv;
  logic [7:0] op_a;
  logic [7:0] op_b;
  logic [7:0] sub_val;

  assign is_sub  = (mode_i == MODE_SUB);
  assign is_ovl  = (mode_i == MODE_OVL);
  // screen and the upper overlay branch work on complements and invert back
  assign inv     = (mode_i == MODE_SCREEN) || (is_ovl && bot_i[7]);
  assign op_a    = inv ? ~top_i : top_i;
  assign op_b    = inv ? ~bot_i : bot_i;
  assign sub_val = (top_i > bot_i) ? (top_i - bot_i) : 8'd0;

  // Stage 1 registers: raw product and flags
  logic [15:0] prod1_q;
  logic        sh_q, inv1_q, sub1_q;
  logic [7:0]  subv1_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      prod1_q <= {8'd0, op_a} * {8'd0, op_b};
      sh_q    <= is_ovl;
      inv1_q  <= inv;
      sub1_q  <= is_sub;
      subv1_q <= sub_val;
    end
  end

  // Stage 2: y = floor((2^k*2p + 255) / 2), then times reciprocal of 255
  logic [16:0] y_val;
  logic [34:0] rprod;

  assign y_val = (sh_q ? {prod1_q, 1'b0} : {1'b0, prod1_q}) + RoundBias;
  assign rprod = {18'd0, y_val} * {17'd0, RecipMul};

  logic [32:0] prod2_q;
  logic        inv2_q, sub2_q;
  logic [7:0]  subv2_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod2_q <= rprod[32:0];
      inv2_q  <= inv1_q;
      sub2_q  <= sub1_q;
      subv2_q <= subv1_q;
    end
  end

  // Quotient is at most 255 for every blend mode
  logic [7:0] quo;
  assign quo   = prod2_q[RecipShift +: 8];
  assign res_o = sub2_q ? subv2_q : (inv2_q ? ~quo : quo);

endmodule
`default_nettype wire

// ===== rtl/pbca_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbca_merge: channel adjust path and result merge
// Runs the add-offset, scale and replicate path alongside the lanes and
// combines it with the lane results into the output register.
// ----------------------------------------------------------------------------
module pbca_merge import pbca_pkg::*; (
  input  wire logic       clk_i,
  input  wire pbca_en_t   en_i,
  input  wire logic [2:0] mode_i,
  input  wire logic [1:0] chsel_i,
  input  wire logic [8:0] offset_i,
  input  wire logic [7:0] scale_i,
  input  wire pix_in_t    pix_i,
  input  wire logic [7:0] lane_b_i,
  input  wire logic [7:0] lane_g_i,
  input  wire logic [7:0] lane_r_i,
  output pix_out_t        pix_o
);

  // Stage 1: pick the selected top channel
  logic       [7:0] sel_c;
  logic signed [9:0] sum_d;

  always_comb begin
    case (chsel_i)
      CH_BLUE:  sel_c = pix_i.top_blue;
      CH_GREEN: sel_c = pix_i.top_green;
      CH_RED:   sel_c = pix_i.top_red;
      default:  sel_c = pix_i.top_blue;
    endcase
  end

  assign sum_d = $signed({2'b00, sel_c}) + $signed({offset_i[8], offset_i});

  logic signed [9:0] sum1_q;
  logic [15:0]       sprod1_q;
  logic [7:0]        c1_q;
  logic [2:0]        mode1_q;
  logic [1:0]        chsel1_q;
  logic [23:0]       top1_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      sum1_q   <= sum_d;
      sprod1_q <= {8'd0, sel_c} * {8'd0, scale_i};
      c1_q     <= sel_c;
      mode1_q  <= mode_i;
      chsel1_q <= chsel_i;
      top1_q   <= {pix_i.top_blue, pix_i.top_green, pix_i.top_red};
    end
  end

  // Stage 2: saturate the adjusted channel
  logic [7:0] clamp_v;
  logic [7:0] scale_v;

  always_comb begin
    if (sum1_q[9]) begin
      clamp_v = 8'd0;
    end else if (sum1_q[8]) begin
      clamp_v = 8'd255;
    end else begin
      clamp_v = sum1_q[7:0];
    end
  end

  assign scale_v = (|sprod1_q[15:8]) ? 8'd255 : sprod1_q[7:0];

  logic [7:0]  adj2_q;
  logic [7:0]  c2_q;
  logic [2:0]  mode2_q;
  logic [1:0]  chsel2_q;
  logic [23:0] top2_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      adj2_q   <= (mode1_q == MODE_ADD) ? clamp_v : scale_v;
      c2_q     <= c1_q;
      mode2_q  <= mode1_q;
      chsel2_q <= chsel1_q;
      top2_q   <= top1_q;
    end
  end

  // Output stage: merge lanes or adjust path
  pix_out_t out_d, out_q;

  always_comb begin
    out_d.out_blue  = top2_q[23:16];
    out_d.out_green = top2_q[15:8];
    out_d.out_red   = top2_q[7:0];
    case (mode2_q)
      MODE_MUL, MODE_SUB, MODE_SCREEN, MODE_OVL: begin
        out_d.out_blue  = lane_b_i;
        out_d.out_green = lane_g_i;
        out_d.out_red   = lane_r_i;
      end
      MODE_ADD, MODE_SCALE: begin
        case (chsel2_q)
          CH_BLUE:  out_d.out_blue  = adj2_q;
          CH_GREEN: out_d.out_green = adj2_q;
          CH_RED:   out_d.out_red   = adj2_q;
          default:  ;
        endcase
      end
      MODE_REPL: begin
        if (chsel2_q inside {CH_BLUE, CH_GREEN, CH_RED}) begin
          out_d.out_blue  = c2_q;
          out_d.out_green = c2_q;
          out_d.out_red   = c2_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      out_q <= out_d;
    end
  end

  assign pix_o = out_q;

endmodule
`default_nettype wire

// ===== rtl/pixel_blend_and_channel_adjust_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_blend_and_channel_adjust_top: per-pixel blend and channel adjust
// Blends a top and a bottom BGR pixel or adjusts one channel of the top pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o/in_data_i carries one top and one
//   bottom pixel per transfer; output channel out_valid_o/out_ready_i/
//   out_data_o carries one result pixel per transfer.
//   Configuration is a write-only port: cfg_we_i, cfg_idx_i, cfg_data_i;
//   write only while no pixel is in flight.
//   Pipeline: three register stages (product stage, reciprocal divide stage,
//   output register); out_valid_o rises once the pixel reaches the output
//   register, and the result transfers when out_ready_i is also high.
//   Throughput: one pixel per clock unless the output stalls; the three
//   channel lanes run side by side and each holds one 8x8 and one 17x18
//   multiplier. Stall: every full stage holds when the stage after it is
//   full and not moving; in_ready_o falls only when all three stages hold
//   data and out_ready_i is low.
//   Reset: pipeline empty, mode multiply, channel red, offset 0, scale 1.
// ----------------------------------------------------------------------------
module pixel_blend_and_channel_adjust_top import pbca_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pix_in_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output pix_out_t                 out_data_o
);

  // Configuration registers
  logic [2:0] mode_q;
  logic [1:0] chsel_q;
  logic [8:0] offset_q;
  logic [7:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RST;
      chsel_q  <= CHSEL_RST;
      offset_q <= OFFSET_RST;
      scale_q  <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:   mode_q   <= cfg_data_i[2:0];
        CFG_CHSEL:  chsel_q  <= cfg_data_i[1:0];
        CFG_OFFSET: offset_q <= cfg_data_i[8:0];
        CFG_SCALE:  scale_q  <= cfg_data_i[7:0];
        default:    ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or draining
  logic v1_q, v2_q, v3_q;
  logic v1_d, v2_d, v3_d;
  logic rdy1, rdy2, rdy3;
  pbca_en_t en;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  assign v1_d = rdy1 ? in_valid_i : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v3_q;

  // Blend lanes, one per channel
  logic [7:0] lane_b, lane_g, lane_r;

  pbca_lane u_lane_b (
    .clk_i  (clk_i),
    .mode_i (mode_q),
    .en_i   (en),
    .top_i  (in_data_i.top_blue),
    .bot_i  (in_data_i.bottom_blue),
    .res_o  (lane_b)
  );

  pbca_lane u_lane_g (
    .clk_i  (clk_i),
    .mode_i (mode_q),
    .en_i   (en),
    .top_i  (in_data_i.top_green),
    .bot_i  (in_data_i.bottom_green),
    .res_o  (lane_g)
  );

  pbca_lane u_lane_r (
    .clk_i  (clk_i),
    .mode_i (mode_q),
    .en_i   (en),
    .top_i  (in_data_i.top_red),
    .bot_i  (in_data_i.bottom_red),
    .res_o  (lane_r)
  );

  // Adjust path and merge into output register
  pbca_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (en),
    .mode_i   (mode_q),
    .chsel_i  (chsel_q),
    .offset_i (offset_q),
    .scale_i  (scale_q),
    .pix_i    (in_data_i),
    .lane_b_i (lane_b),
    .lane_g_i (lane_g),
    .lane_r_i (lane_r),
    .pix_o    (out_data_o)
  );

  // Input backpressure only when the whole pipeline is full and stalled
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && !out_ready_i))
    else $error("input stalled while pipeline has room");

  // An accepted input transfer lands in stage one
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted pixel lost at stage one");

  // Replicate mode gives a gray pixel
  a_repl_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_q == MODE_REPL && chsel_q <= CH_RED && $stable(mode_q)
     && $stable(chsel_q))
    |-> (out_data_o.out_blue == out_data_o.out_green
         && out_data_o.out_green == out_data_o.out_red))
    else $error("replicate mode result is not gray");

endmodule
`default_nettype wire
